/* rtl/xhrf_pkg.sv */
// Package for the chained 64-bit row/field hash core.
// Holds the xxHash primes, the field classes, the queue entry type and a rotate helper.
// Used by every module under rtl except xhrf_mul.
package xhrf_pkg;

	localparam int SLEN_W = 32;  // string length counter width, wraps

	localparam logic [63:0] P1 = 64'h9E37_79B1_85EB_CA87;
	localparam logic [63:0] P2 = 64'hC2B2_AE3D_27D4_EB4F;
	localparam logic [63:0] P3 = 64'h1656_67B1_9E37_79F9;
	localparam logic [63:0] P4 = 64'h85EB_CA77_C2B2_AE63;
	localparam logic [63:0] P5 = 64'h27D4_EB2F_1656_67C5;

	localparam logic [63:0] SEED_RESET = 64'd42;

	localparam logic [2:0] OP_INT32   = 3'd1;
	localparam logic [2:0] OP_INT64   = 3'd2;
	localparam logic [2:0] OP_FLOAT32 = 3'd3;
	localparam logic [2:0] OP_FLOAT64 = 3'd4;
	localparam logic [2:0] OP_CHUNK   = 3'd5;

	typedef enum logic [1:0] {
		K_NULL  = 2'd0,
		K_HALF  = 2'd1,
		K_WORD  = 2'd2,
		K_CHUNK = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] value;
		logic [3:0]  nbytes;   // clamped byte count, 8 for non-last chunks
		logic        clast;
		logic        rfirst;
		logic        rlast;
	} qentry_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

endpackage

/* rtl/xhrf_front.sv */
// Front end: accepts field items, tracks row start, classifies and normalizes them.
// Pushes one qentry_t per accepted item into the queue. Depends on xhrf_pkg.
module xhrf_front import xhrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  opcode,
	input  logic [63:0] value,
	input  logic [3:0]  byte_count,
	input  logic        chunk_last,
	input  logic        row_last,
	input  logic        accept,
	output qentry_t     entry
);

	logic row_open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_open_q <= 1'b0;
		end else if (accept) begin
			row_open_q <= !row_last;
		end
	end

	always_comb begin
		entry.kind   = K_NULL;
		entry.value  = value;
		entry.nbytes = 4'd8;
		entry.clast  = chunk_last;
		entry.rfirst = !row_open_q;
		entry.rlast  = row_last;
		unique case (opcode)
			OP_INT32: entry.kind = K_HALF;
			OP_INT64: entry.kind = K_WORD;
			OP_FLOAT32: begin
				entry.kind = K_HALF;
				// negative zero hashes like zero
				if (value[30:0] == 31'd0) entry.value = 64'd0;
			end
			OP_FLOAT64: begin
				entry.kind = K_WORD;
				if (value[62:0] == 63'd0) entry.value = 64'd0;
			end
			OP_CHUNK: begin
				entry.kind = K_CHUNK;
				if (chunk_last && byte_count < 4'd8) entry.nbytes = byte_count;
			end
			default: entry.kind = K_NULL;
		endcase
	end

endmodule

/* rtl/xhrf_queue.sv */
// Two-entry queue of classified items between the front end and the hash engine.
// Depends on xhrf_pkg for qentry_t.
module xhrf_queue import xhrf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    nonempty,
	output qentry_t pop_data
);

	qentry_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				mem_q[wp_q] <= push_data;
				wp_q        <= !wp_q;
			end
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* rtl/xhrf_mul.sv */
// Low 64 bits of a 64x64 product from one 32x32 multiplier, reused for each partial product.
// done pulses for one cycle; product stays valid until the next start. No dependencies.
module xhrf_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] product
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [1:0]  ph_q;
	logic        act_q;
	logic        done_q;
	logic [63:0] pp_q;
	logic [31:0] cx_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] m;

	always_comb begin
		ma = (ph_q == 2'd1) ? a_q[63:32] : a_q[31:0];
		mb = (ph_q == 2'd2) ? b_q[63:32] : b_q[31:0];
		m  = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 2'd0;
			act_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= act_q && !start && ph_q == 2'd2;
			if (start) begin
				a_q   <= a;
				b_q   <= b;
				act_q <= 1'b1;
				ph_q  <= 2'd0;
			end else if (act_q) begin
				case (ph_q)
					2'd0: pp_q <= m;
					2'd1: cx_q <= m[31:0];
					default: begin
						cx_q  <= cx_q + m[31:0];
						act_q <= 1'b0;
					end
				endcase
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	assign done    = done_q;
	assign product = pp_q + {cx_q, 32'd0};

endmodule

/* rtl/xhrf_back.sv */
// Hash engine: sequences xxHash rounds, stripes, merge and final mix over one multiplier.
// Holds running hash, lane accumulators, pending words and the result register.
// Depends on xhrf_pkg and xhrf_mul.
module xhrf_back import xhrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] seed,
	input  logic        q_valid,
	input  qentry_t     q_data,
	output logic        q_pop,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [63:0] res_data
);

	typedef enum logic [14:0] {
		ST_IDLE = 15'h0001,
		ST_W1   = 15'h0002,
		ST_W2   = 15'h0004,
		ST_W3   = 15'h0008,
		ST_M3   = 15'h0010,
		ST_H1   = 15'h0020,
		ST_H2   = 15'h0040,
		ST_B1   = 15'h0080,
		ST_B2   = 15'h0100,
		ST_F1   = 15'h0200,
		ST_F2   = 15'h0400,
		ST_S2   = 15'h0800,
		ST_FIN  = 15'h1000,
		ST_TAIL = 15'h2000,
		ST_END  = 15'h4000
	} state_t;

	typedef enum logic [1:0] {
		MD_SCALAR = 2'd0,
		MD_TAIL   = 2'd1,
		MD_MERGE  = 2'd2,
		MD_STRIPE = 2'd3
	} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic              busy_q;
	logic [63:0]       rh_q;
	logic [63:0]       acc_q;
	logic [63:0]       t_q;
	logic [63:0]       w_q;
	logic [63:0]       tv_q;
	logic [3:0]        bc_q;
	logic [1:0]        li_q;
	logic [1:0]        wi_q;
	logic [63:0]       lane_q [4];
	logic [63:0]       pend_q [4];
	logic [1:0]        pcnt_q;
	logic [SLEN_W-1:0] slen_q;
	logic              seen_q;
	logic              rlast_q;
	logic              clast_q;
	logic              out_valid_q;
	logic [63:0]       out_data_q;

	logic        is_mul;
	logic        mul_start;
	logic        mul_done;
	logic [63:0] ma;
	logic [63:0] mb;
	logic [63:0] prod;
	logic [63:0] rh_eff;
	logic [63:0] lane_sum;
	logic        slot_free;
	logic        last_full;

	assign is_mul = state_q == ST_W1 || state_q == ST_W2 || state_q == ST_W3 ||
		state_q == ST_M3 || state_q == ST_H1 || state_q == ST_H2 || state_q == ST_B1 ||
		state_q == ST_B2 || state_q == ST_F1 || state_q == ST_F2 || state_q == ST_S2;
	assign mul_start = is_mul && !busy_q;
	assign q_pop     = state_q == ST_IDLE && q_valid;
	assign rh_eff    = q_data.rfirst ? seed : rh_q;
	assign slot_free = !out_valid_q || res_ready;
	assign last_full = q_data.nbytes == 4'd8;
	assign lane_sum  = rotl(lane_q[0], 1) + rotl(lane_q[1], 7) +
		rotl(lane_q[2], 12) + rotl(lane_q[3], 18);

	always_comb begin
		ma = w_q;
		mb = P2;
		unique case (state_q)
			ST_W1: begin ma = w_q;                           mb = P2; end
			ST_W2: begin ma = rotl(t_q, 31);                 mb = P1; end
			ST_W3: begin ma = rotl(acc_q, 27);               mb = P1; end
			ST_M3: begin ma = acc_q;                         mb = P1; end
			ST_H1: begin ma = {32'd0, tv_q[31:0]};           mb = P1; end
			ST_H2: begin ma = rotl(acc_q, 23);               mb = P2; end
			ST_B1: begin ma = {56'd0, tv_q[7:0]};            mb = P5; end
			ST_B2: begin ma = rotl(acc_q, 11);               mb = P1; end
			ST_F1: begin ma = acc_q ^ (acc_q >> 33);         mb = P2; end
			ST_F2: begin ma = acc_q ^ (acc_q >> 29);         mb = P3; end
			ST_S2: begin ma = rotl(lane_q[li_q] + t_q, 31);  mb = P1; end
			default: begin ma = w_q; mb = P2; end
		endcase
	end

	xhrf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (ma),
		.b       (mb),
		.done    (mul_done),
		.product (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MD_SCALAR;
			busy_q      <= 1'b0;
			rh_q        <= 64'd0;
			pcnt_q      <= 2'd0;
			slen_q      <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a new row hash loaded in ST_END takes over the slot
			if (out_valid_q && res_ready && !(state_q == ST_END && rlast_q))
				out_valid_q <= 1'b0;
			if (mul_start) busy_q <= 1'b1;
			else if (mul_done) busy_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						rh_q    <= rh_eff;
						rlast_q <= q_data.rlast;
						clast_q <= q_data.kind == K_CHUNK && q_data.clast;
						tv_q    <= q_data.value;
						if (q_data.kind != K_CHUNK) begin
							pcnt_q <= 2'd0;
							slen_q <= '0;
							seen_q <= 1'b0;
						end
						case (q_data.kind)
							K_HALF: begin
								acc_q   <= rh_eff + P5 + 64'd4;
								mode_q  <= MD_SCALAR;
								state_q <= ST_H1;
							end
							K_WORD: begin
								acc_q   <= rh_eff + P5 + 64'd8;
								w_q     <= q_data.value;
								mode_q  <= MD_SCALAR;
								state_q <= ST_W1;
							end
							K_CHUNK: begin
								slen_q  <= slen_q + SLEN_W'(q_data.nbytes);
								bc_q    <= last_full ? 4'd0 : q_data.nbytes;
								wi_q    <= 2'd0;
								if (last_full) begin
									pend_q[pcnt_q] <= q_data.value;
									pcnt_q         <= pcnt_q + 2'd1;
								end
								if (last_full && pcnt_q == 2'd3) begin
									if (!seen_q) begin
										lane_q[0] <= rh_eff + P1 + P2;
										lane_q[1] <= rh_eff + P2;
										lane_q[2] <= rh_eff;
										lane_q[3] <= rh_eff - P1;
										seen_q    <= 1'b1;
									end
									li_q    <= 2'd0;
									w_q     <= pend_q[0];
									mode_q  <= MD_STRIPE;
									state_q <= ST_W1;
								end else begin
									state_q <= q_data.clast ? ST_FIN : ST_END;
								end
							end
							default: state_q <= ST_END;
						endcase
					end
				end
				ST_W1: if (mul_done) begin
					t_q     <= prod;
					state_q <= mode_q == MD_STRIPE ? ST_S2 : ST_W2;
				end
				ST_W2: if (mul_done) begin
					acc_q   <= acc_q ^ prod;
					state_q <= mode_q == MD_MERGE ? ST_M3 : ST_W3;
				end
				ST_W3: if (mul_done) begin
					acc_q <= prod + P4;
					if (mode_q == MD_TAIL) begin
						wi_q    <= wi_q + 2'd1;
						state_q <= ST_TAIL;
					end else begin
						state_q <= ST_F1;
					end
				end
				ST_M3: if (mul_done) begin
					if (li_q == 2'd3) begin
						acc_q   <= prod + P4 + 64'(slen_q);
						mode_q  <= MD_TAIL;
						state_q <= ST_TAIL;
					end else begin
						acc_q   <= prod + P4;
						li_q    <= li_q + 2'd1;
						w_q     <= lane_q[li_q + 2'd1];
						state_q <= ST_W1;
					end
				end
				ST_S2: if (mul_done) begin
					lane_q[li_q] <= prod;
					if (li_q == 2'd3) begin
						state_q <= clast_q ? ST_FIN : ST_END;
					end else begin
						li_q    <= li_q + 2'd1;
						w_q     <= pend_q[li_q + 2'd1];
						state_q <= ST_W1;
					end
				end
				ST_H1: if (mul_done) begin
					acc_q   <= acc_q ^ prod;
					state_q <= ST_H2;
				end
				ST_H2: if (mul_done) begin
					acc_q <= prod + P3;
					if (mode_q == MD_TAIL) begin
						tv_q    <= tv_q >> 32;
						bc_q    <= bc_q - 4'd4;
						state_q <= ST_TAIL;
					end else begin
						state_q <= ST_F1;
					end
				end
				ST_B1: if (mul_done) begin
					acc_q   <= acc_q ^ prod;
					state_q <= ST_B2;
				end
				ST_B2: if (mul_done) begin
					acc_q   <= prod;
					tv_q    <= tv_q >> 8;
					bc_q    <= bc_q - 4'd1;
					state_q <= ST_TAIL;
				end
				ST_F1: if (mul_done) begin
					acc_q   <= prod;
					state_q <= ST_F2;
				end
				ST_F2: if (mul_done) begin
					rh_q    <= prod ^ (prod >> 32);
					state_q <= ST_END;
				end
				ST_FIN: begin
					if (seen_q) begin
						acc_q   <= lane_sum;
						li_q    <= 2'd0;
						w_q     <= lane_q[0];
						mode_q  <= MD_MERGE;
						state_q <= ST_W1;
					end else begin
						acc_q   <= rh_q + P5 + 64'(slen_q);
						mode_q  <= MD_TAIL;
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					if (wi_q < pcnt_q) begin
						w_q     <= pend_q[wi_q];
						state_q <= ST_W1;
					end else if (bc_q >= 4'd4) begin
						state_q <= ST_H1;
					end else if (bc_q != 4'd0) begin
						state_q <= ST_B1;
					end else begin
						state_q <= ST_F1;
					end
				end
				ST_END: begin
					if (clast_q || rlast_q) begin
						pcnt_q <= 2'd0;
						slen_q <= '0;
						seen_q <= 1'b0;
					end
					if (!rlast_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= rh_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_data_q;

	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !busy_q)
		else $error("multiplier busy while engine idle");

	a_done_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> busy_q && is_mul)
		else $error("multiply completed outside a multiply step");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_END && rlast_q && slot_free |=> out_valid_q && state_q == ST_IDLE)
		else $error("row hash not loaded on row end");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q != ST_IDLE || !$past(q_data.rlast) || $past(q_data.kind) == K_NULL)
		else $error("item popped without engine leaving idle");

endmodule

/* rtl/xhrf_top_dummy_unused.sv */
// Row seed register for the hash core: loads on a configuration write, resets to 42.
// Depends on xhrf_pkg.
module xhrf_seed import xhrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [63:0] wdata,
	output logic [63:0] seed
);

	logic [63:0] seed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (we) begin
			seed_q <= wdata;
		end
	end

	assign seed = seed_q;

endmodule

/* rtl/xxhash64_row_field_hash_core.sv */
// Top level of the chained 64-bit row/field hash core.
// Instantiates xhrf_front, xhrf_queue, xhrf_back and xhrf_seed; depends on xhrf_pkg.
//
// Each field item is hashed with the running hash as seed; the first field of a row
// starts from the row_seed register (reset value 42) and the row hash is delivered on
// the item that carries tlast. Items are taken into a two-entry queue and worked on one
// at a time by a hash engine that owns a single 32x32 multiplier; every 64-bit multiply
// step is issued, built from three partial products and written back. A null field
// goes straight to the end state; int32/float32 take four steps, int64/float64 five.
// A byte chunk that completes a 32-byte stripe adds eight steps; the last chunk of a
// string adds three steps per lane on merge, three per pending word, two per 4-byte or
// single-byte tail round, and two for the final mix.
// Write row_seed only while the core is idle.
module xxhash64_row_field_hash_core import xhrf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        row_seed_we,
	input  logic [63:0] row_seed_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // value[63:0], byte_count[67:64], chunk_last[68], zero pad
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	input  logic        s_tlast,   // row_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // row_hash[63:0]
);

	logic    accept;
	logic    q_full;
	logic    q_nonempty;
	logic    q_pop;
	qentry_t push_entry;
	qentry_t pop_entry;
	logic [63:0] seed;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && !q_full;

	xhrf_seed u_seed (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (row_seed_we),
		.wdata  (row_seed_wdata),
		.seed   (seed)
	);

	xhrf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (s_tuser),
		.value      (s_tdata[63:0]),
		.byte_count (s_tdata[67:64]),
		.chunk_last (s_tdata[68]),
		.row_last   (s_tlast),
		.accept     (accept),
		.entry      (push_entry)
	);

	xhrf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.pop_data  (pop_entry)
	);

	xhrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (seed),
		.q_valid   (q_nonempty),
		.q_data    (pop_entry),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata)
	);

endmodule

/* tb/xxhash64_row_field_hash_core_tb.sv */
// Testbench for xxhash64_row_field_hash_core: directed and random rows under
// random source bursts and sink stalls, checked against a built-in row hash predictor.
// Depends on xhrf_pkg and the core RTL.
module xxhash64_row_field_hash_core_tb import xhrf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_NULL = 3'd0;
	localparam logic [2:0] OP_RSV6 = 3'd6;
	localparam logic [2:0] OP_RSV7 = 3'd7;
	localparam int DRAIN_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 3000;

	function automatic logic [63:0] rot64(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] avalanche(input logic [63:0] h);
		h = h ^ (h >> 33);
		h = h * P2;
		h = h ^ (h >> 29);
		h = h * P3;
		return h ^ (h >> 32);
	endfunction

	function automatic logic [63:0] mix_word(input logic [63:0] h, input logic [63:0] w);
		h = h ^ (rot64(w * P2, 31) * P1);
		return rot64(h, 27) * P1 + P4;
	endfunction

	function automatic logic [63:0] mix_half(input logic [63:0] h, input logic [63:0] w);
		h = h ^ ({32'd0, w[31:0]} * P1);
		return rot64(h, 23) * P2 + P3;
	endfunction

	function automatic logic [63:0] mix_byte(input logic [63:0] h, input logic [63:0] b);
		h = h ^ ({56'd0, b[7:0]} * P5);
		return rot64(h, 11) * P1;
	endfunction

	class row_hash_scoreboard;
		logic [63:0] seed = SEED_RESET;
		logic [63:0] running = '0;
		bit in_row = 0;
		logic [63:0] lanes[4];
		logic [63:0] words[4];
		int nwords = 0;
		logic [SLEN_W-1:0] str_len = '0;
		bit lanes_live = 0;
		logic [63:0] hash_q[$];
		int errors = 0;
		int nchecked = 0;

		function void drop_string();
			nwords = 0;
			str_len = '0;
			lanes_live = 0;
		endfunction

		function void stripe();
			if (!lanes_live) begin
				lanes[0] = running + P1 + P2;
				lanes[1] = running + P2;
				lanes[2] = running;
				lanes[3] = running - P1;
				lanes_live = 1;
			end
			for (int k = 0; k < 4; k++)
				lanes[k] = rot64(lanes[k] + words[k] * P2, 31) * P1;
		endfunction

		function logic [63:0] merged();
			logic [63:0] h;
			h = rot64(lanes[0], 1) + rot64(lanes[1], 7) + rot64(lanes[2], 12)
				+ rot64(lanes[3], 18);
			for (int k = 0; k < 4; k++) begin
				h = h ^ (rot64(lanes[k] * P2, 31) * P1);
				h = h * P1 + P4;
			end
			return h;
		endfunction

		function void chunk(input logic [63:0] v, input logic [3:0] cnt, input bit clast);
			int n;
			logic [63:0] h;
			n = !clast ? 8 : (cnt > 8 ? 8 : int'(cnt));
			str_len = str_len + SLEN_W'(n);
			if (n == 8) begin
				words[nwords] = v;
				if (nwords == 3) begin
					stripe();
					nwords = 0;
				end else begin
					nwords++;
				end
			end
			if (clast) begin
				h = lanes_live ? merged() : running + P5;
				h = h + 64'(str_len);
				for (int k = 0; k < nwords; k++)
					h = mix_word(h, words[k]);
				if (n < 8) begin
					if (n >= 4) begin
						h = mix_half(h, v);
						v = v >> 32;
						n -= 4;
					end
					while (n > 0) begin
						h = mix_byte(h, v);
						v = v >> 8;
						n--;
					end
				end
				running = avalanche(h);
				drop_string();
			end
		endfunction

		function void note_field(input logic [2:0] op, input logic [63:0] v,
				input logic [3:0] cnt, input bit clast, input bit rlast);
			if (!in_row) begin
				running = seed;
				in_row = 1;
			end
			if (op != OP_CHUNK)
				drop_string();
			case (op)
				OP_INT32: running = avalanche(mix_half(running + P5 + 4, v));
				OP_FLOAT32: begin
					if (v[30:0] == '0)
						v = '0;
					running = avalanche(mix_half(running + P5 + 4, v));
				end
				OP_INT64: running = avalanche(mix_word(running + P5 + 8, v));
				OP_FLOAT64: begin
					if (v[62:0] == '0)
						v = '0;
					running = avalanche(mix_word(running + P5 + 8, v));
				end
				OP_CHUNK: chunk(v, cnt, clast);
				default: ;
			endcase
			if (rlast) begin
				drop_string();
				in_row = 0;
				hash_q.push_back(running);
			end
		endfunction

		function void check_hash(input logic [63:0] got);
			logic [63:0] want;
			nchecked++;
			if (hash_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected row hash: expected none, actual %h", $time, got);
			end else begin
				want = hash_q.pop_front();
				if (want !== got) begin
					errors++;
					$display("%0t: row hash mismatch: expected %h, actual %h",
						$time, want, got);
				end
			end
		endfunction
	endclass

	typedef struct {
		logic [2:0]  op;
		logic [63:0] v;
		logic [3:0]  cnt;
		bit          clast;
		bit          rlast;
	} field_item_t;

	logic        clk;
	logic        arst_n;
	logic        row_seed_we;
	logic [63:0] row_seed_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // value[63:0], byte_count[67:64], chunk_last[68], zero pad
	logic [2:0]  s_tuser;   // opcode[2:0]
	logic        s_tlast;   // row_last
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // row_hash[63:0]

	row_hash_scoreboard sb;
	field_item_t stim_q[$];
	int burst_left = 0;
	int idle_cycles = 0;
	bit hold_done = 0;

	xxhash64_row_field_hash_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.row_seed_we(row_seed_we), .row_seed_wdata(row_seed_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// monitor: transfers on both sides
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_field(s_tuser, s_tdata[63:0], s_tdata[67:64], s_tdata[68], s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_hash(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// sink: random stall stretches, one long hold-off to back up the core
	initial begin
		int left;
		int mode;
		int hold;
		left = 0;
		mode = 0;
		hold = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				m_tready = 0;
			end else if (!hold_done && sb != null && sb.nchecked >= 40) begin
				hold_done = 1;
				hold = LONG_HOLD;
				m_tready = 0;
			end else begin
				if (left == 0) begin
					left = $urandom_range(1, 60);
					mode = $urandom_range(0, 3);
				end
				left--;
				case (mode)
					0: m_tready = 1;
					1: m_tready = ($urandom_range(0, 3) != 0);
					2: m_tready = ($urandom_range(0, 3) == 0);
					default: m_tready = 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h8000_0000_0000_0000;
			3: return {$urandom, 32'h8000_0000};
			4: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void push(input logic [2:0] op, input logic [63:0] v,
			input logic [3:0] cnt, input bit clast, input bit rlast);
		field_item_t it;
		it.op = op;
		it.v = v;
		it.cnt = cnt;
		it.clast = clast;
		it.rlast = rlast;
		stim_q.push_back(it);
	endfunction

	// well-formed byte string of len bytes; rlast on its final chunk
	function automatic void push_string(input int len, input bit rlast);
		int nfull;
		int tail;
		logic [3:0] lc;
		nfull = (len == 0) ? 0 : (len - 1) / 8;
		tail = len - 8 * nfull;
		for (int k = 0; k < nfull; k++)
			push(OP_CHUNK, pick_value(), 4'($urandom_range(0, 15)), 0, 0);
		lc = 4'(tail);
		if (tail == 8 && $urandom_range(0, 3) == 0)
			lc = 4'($urandom_range(9, 15));
		push(OP_CHUNK, pick_value(), lc, 1, rlast);
	endfunction

	function automatic void push_random_row();
		int nf;
		bit rl;
		nf = $urandom_range(1, 6);
		for (int f = 0; f < nf; f++) begin
			rl = (f == nf - 1);
			case ($urandom_range(0, 19))
				0, 1: push(OP_INT32, pick_value(), 4'($urandom), 1'($urandom), rl);
				2, 3: push(OP_INT64, pick_value(), 4'($urandom), 1'($urandom), rl);
				4, 5: push(OP_FLOAT32, pick_value(), 4'($urandom), 1'($urandom), rl);
				6, 7: push(OP_FLOAT64, pick_value(), 4'($urandom), 1'($urandom), rl);
				8: push(OP_NULL, pick_value(), 4'($urandom), 1'($urandom), rl);
				9: push($urandom_range(0, 1) ? OP_RSV6 : OP_RSV7, pick_value(),
					4'($urandom), 1'($urandom), rl);
				10: begin
					// broken string: unfinished chunks, then the row goes on or ends
					for (int k = $urandom_range(1, 6); k > 0; k--)
						push(OP_CHUNK, pick_value(), 4'($urandom), 0, 0);
					if (rl || $urandom_range(0, 1))
						push(OP_CHUNK, pick_value(), 4'($urandom), 0, rl);
				end
				11: push_string($urandom_range(100, 260), rl);
				default: push_string($urandom_range(0, 72), rl);
			endcase
		end
	endfunction

	task automatic send_item(input field_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				s_tvalid = 0;
				repeat ($urandom_range(0, 25)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tdata = {3'd0, it.clast, it.cnt, it.v};
		s_tuser = it.op;
		s_tlast = it.rlast;
		s_tvalid = 1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic run_stimulus();
		while (stim_q.size() > 0)
			send_item(stim_q.pop_front());
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic drain();
		while (sb.hash_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [63:0] val);
		@(negedge clk);
		row_seed_we = 1;
		row_seed_wdata = val;
		sb.seed = val;
		@(negedge clk);
		row_seed_we = 0;
		row_seed_wdata = {$urandom, $urandom};
	endtask

	initial begin
		logic [63:0] seeds[4];
		int target;
		sb = new();
		arst_n = 0;
		row_seed_we = 0;
		row_seed_wdata = '0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_NULL;
		s_tlast = 0;
		seeds[0] = '0;
		seeds[1] = 64'h8000_0000_0000_0000;
		seeds[2] = 64'h7FFF_FFFF_FFFF_FFFF;
		seeds[3] = {$urandom, $urandom};
		repeat (11) @(negedge clk);
		arst_n = 1;

		// directed, reset seed
		push(OP_INT32, '0, 0, 0, 1);
		push(OP_INT32, '1, 0, 0, 0);
		push(OP_INT64, 64'h8000_0000_0000_0000, 0, 0, 0);
		push(OP_INT64, '1, 4'hF, 1, 1);
		push(OP_FLOAT32, 64'h0, 0, 0, 0);
		push(OP_FLOAT32, 64'hFFFF_FFFF_8000_0000, 0, 0, 0);
		push(OP_FLOAT64, 64'h0, 0, 0, 0);
		push(OP_FLOAT64, 64'h8000_0000_0000_0000, 0, 0, 1);
		push(OP_NULL, '1, 0, 0, 0);
		push(OP_RSV6, '1, 0, 0, 0);
		push(OP_RSV7, '1, 0, 0, 1);
		push(OP_CHUNK, '1, 0, 1, 1);                // empty string
		push(OP_CHUNK, '1, 4'hF, 1, 0);             // oversized count
		push(OP_CHUNK, pick_value(), 4'd3, 0, 0);   // count ignored, then interrupted
		push(OP_INT32, 64'd7, 0, 0, 0);
		push(OP_CHUNK, pick_value(), 4'd8, 0, 1);   // unfinished string ended by row
		push_string(37, 0);
		push_string(13, 1);
		run_stimulus();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			write_seed(seeds[ph]);
			target = 430;
			while (stim_q.size() < target)
				push_random_row();
			run_stimulus();
			drain();
		end

		if (sb.hash_q.size() != 0)
			sb.errors++;
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
